// ===== design/ldps_pkg.sv =====
// Shared types, weights and the linear sRGB lookup table for the luminance statistics block.
`timescale 1ns / 1ps

package ldps_pkg;

  // Per-pixel routing flags carried with each word
  typedef struct packed {
    logic to_global;
    logic to_region;
    logic last;
  } ldps_route_t;

  // Dark threshold after reset, Q0.16
  localparam logic [15:0] DARK_THR_RESET = 16'd11731;

  // Rec.709 luminance weights, Q0.16
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  // Words between the classifying front and the accumulating back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef logic [255:0][16:0] lin_rom_t;

  // Q30 multiply with rounding
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    qmul = (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic logic [63:0] pow5_q30(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = qmul(y, y);
    y4 = qmul(y2, y2);
    pow5_q30 = qmul(y4, y);
  endfunction

  // Linear value of one sRGB code, Q1.16 (elaboration only)
  function automatic logic [16:0] lin_entry(input logic [63:0] i);
    logic [63:0] num;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] v;
    if (i <= 64'd10) begin
      v = (64'd6553600 * i + 64'd164730) / 64'd329460;
    end else begin
      num = 64'd1000 * i + 64'd14025;
      t   = ((num << 30) + 64'd134512) / 64'd269025;
      t2  = qmul(t, t);
      lo  = 64'd0;
      hi  = 64'd1 << 30;
      // largest fifth root of t^2, i.e. t^0.4
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (pow5_q30(mid) <= t2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
      v = (qmul(t2, lo) + 64'd8192) >> 14;
    end
    lin_entry = v[16:0];
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t r;
    for (int k = 0; k < 256; k++) begin
      r[k] = lin_entry(64'(k));
    end
    return r;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

// ===== design/ldps_front.sv =====
// Front pipeline: alpha premultiply, linear lookup, luminance and dark classification.
`timescale 1ns / 1ps

module ldps_front import ldps_pkg::*; #(
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                red_in_i,
  input  logic [7:0]                green_in_i,
  input  logic [7:0]                blue_in_i,
  input  logic [7:0]                alpha_in_i,
  input  logic                      to_global_i,
  input  logic                      to_region_i,
  input  logic                      last_pixel_i,
  input  logic [15:0]               dark_threshold_i,
  input  logic                      queue_full_i,
  output logic                      push_o,
  output logic [LUMA_FRAC_BITS:0]   push_lum_o,
  output logic                      push_dark_o,
  output ldps_route_t               push_route_o
);

  localparam int unsigned LW = LUMA_FRAC_BITS + 1;
  localparam int unsigned CW = LUMA_FRAC_BITS + 17;
  localparam logic [33:0] LUM_RND = 34'd1 << (31 - LUMA_FRAC_BITS);

  // round(c * a / 255), exact for all byte pairs
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] t;
    logic [16:0] v;
    p = 16'(c) * 16'(a);
    t = 17'(p) + 17'd128;
    v = (t + (t >> 8)) >> 8;
    premul = (v > 17'd255) ? 8'd255 : v[7:0];
  endfunction

  logic              vld1_q, vld2_q, vld3_q;
  logic [7:0]        r1_q, g1_q, b1_q;
  ldps_route_t       rt1_q, rt2_q, rt3_q;
  logic [32:0]       pr_q, pg_q, pb_q;
  logic [LW-1:0]     lum3_q;
  logic              dark3_q;
  logic              adv;
  logic [33:0]       acc;
  logic [LW-1:0]     lum;
  logic [CW-1:0]     lum_cmp;
  logic [CW-1:0]     thr_cmp;

  // Advance the whole pipe unless the last stage is blocked by a full queue
  assign adv        = !vld3_q || !queue_full_i;
  assign in_stall_o = !adv;

  // Weighted sum and rounding to the luminance precision
  assign acc     = 34'(pr_q) + 34'(pg_q) + 34'(pb_q) + LUM_RND;
  assign lum     = acc[32 -: LW];
  assign lum_cmp = {lum, 16'd0};
  assign thr_cmp = {1'b0, dark_threshold_i, {LUMA_FRAC_BITS{1'b0}}};

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (adv) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // Stage payloads: premultiply, lookup and weight, sum and classify
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q    <= premul(red_in_i, alpha_in_i);
      g1_q    <= premul(green_in_i, alpha_in_i);
      b1_q    <= premul(blue_in_i, alpha_in_i);
      rt1_q   <= '{to_global: to_global_i, to_region: to_region_i, last: last_pixel_i};
      pr_q    <= 33'(LIN_ROM[r1_q]) * 33'(W_RED);
      pg_q    <= 33'(LIN_ROM[g1_q]) * 33'(W_GREEN);
      pb_q    <= 33'(LIN_ROM[b1_q]) * 33'(W_BLUE);
      rt2_q   <= rt1_q;
      lum3_q  <= lum;
      dark3_q <= (lum_cmp < thr_cmp);
      rt3_q   <= rt2_q;
    end
  end

  assign push_o       = vld3_q && !queue_full_i;
  assign push_lum_o   = lum3_q;
  assign push_dark_o  = dark3_q;
  assign push_route_o = rt3_q;

endmodule

// ===== design/ldps_fifo.sv =====
// Short word queue between the front pipeline and the accumulating back end.
`timescale 1ns / 1ps

module ldps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    cnt_q;

  assign full_o     = (cnt_q == NW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/ldps_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all end-of-frame divisions.
`timescale 1ns / 1ps

module ldps_div #(
  parameter int unsigned NW  = 37,
  parameter int unsigned DVW = 20,
  parameter int unsigned QW  = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic           done_o,
  output logic [QW-1:0]  quotient_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [NW-1:0] rem_q;
  logic [NW-1:0] ds_q;
  logic [QW-1:0] q_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  // Load on start while idle, then test and subtract one shifted divisor per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      ds_q   <= '0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        rem_q  <= dividend_i;
        ds_q   <= NW'(divisor_i) << (QW - 1);
        q_q    <= '0;
        cnt_q  <= CW'(QW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (rem_q >= ds_q) begin
          rem_q <= rem_q - ds_q;
          q_q   <= {q_q[QW-2:0], 1'b1};
        end else begin
          q_q   <= {q_q[QW-2:0], 1'b0};
        end
        ds_q  <= ds_q >> 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = q_q;

endmodule

// ===== design/ldps_back.sv =====
// Back end: per-set accumulators, end-of-frame division sequence and the result register.
`timescale 1ns / 1ps

module ldps_back import ldps_pkg::*; #(
  parameter int unsigned COUNT_BITS     = 20,
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    queue_empty_i,
  output logic                    pop_o,
  input  logic [LUMA_FRAC_BITS:0] lum_i,
  input  logic                    dark_i,
  input  ldps_route_t             route_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [15:0]             global_average_o,
  output logic [16:0]             global_dark_ratio_o,
  output logic [15:0]             region_average_o,
  output logic [16:0]             region_dark_ratio_o,
  output logic                    stats_valid_o
);

  localparam int unsigned QW    = ((LUMA_FRAC_BITS > 16) ? LUMA_FRAC_BITS : 16) + 1;
  localparam int unsigned NW    = COUNT_BITS + QW;
  localparam int unsigned SW    = COUNT_BITS + LUMA_FRAC_BITS;
  localparam int unsigned EW    = QW + 8;
  localparam int unsigned SH_DN = (LUMA_FRAC_BITS > 16) ? LUMA_FRAC_BITS - 16 : 1;
  localparam int unsigned SH_UP = (LUMA_FRAC_BITS < 16) ? 16 - LUMA_FRAC_BITS : 0;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] ST_ACC  = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;

  localparam logic [1:0] SEL_GMEAN  = 2'd0;
  localparam logic [1:0] SEL_GRATIO = 2'd1;
  localparam logic [1:0] SEL_RMEAN  = 2'd2;
  localparam logic [1:0] SEL_RRATIO = 2'd3;

  // Quotient to Q0.16 mean, rounded and saturated
  function automatic logic [15:0] to_mean(input logic [QW-1:0] q);
    logic [EW-1:0] e;
    e = EW'(q);
    if (LUMA_FRAC_BITS > 16) begin
      e = (e + (EW'(1) << (SH_DN - 1))) >> SH_DN;
    end else begin
      e = e << SH_UP;
    end
    to_mean = (e > EW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  function automatic logic [16:0] to_ratio(input logic [QW-1:0] q);
    to_ratio = (q > QW'(17'h10000)) ? 17'h10000 : q[16:0];
  endfunction

  logic [2:0]            state_q;
  logic [1:0]            sel_q;
  logic [SW-1:0]         gsum_q, rsum_q;
  logic [COUNT_BITS-1:0] gcnt_q, gdark_q, rcnt_q, rdark_q;
  logic [15:0]           gavg_q, ravg_q;
  logic [16:0]           gratio_q, rratio_q;
  logic                  svalid_q;
  logic                  out_valid_q;
  logic [15:0]           out_gavg_q, out_ravg_q;
  logic [16:0]           out_gratio_q, out_rratio_q;
  logic                  out_svalid_q;
  logic                  pop;
  logic [NW-1:0]         dvd;
  logic [COUNT_BITS-1:0] dvs;
  logic                  div_start;
  logic                  div_done;
  logic [QW-1:0]         div_q;

  assign pop       = (state_q == ST_ACC) && !queue_empty_i;
  assign pop_o     = pop;
  assign div_start = (state_q == ST_LOAD);

  // Select the operands of the current division
  always_comb begin
    case (sel_q)
      SEL_GMEAN: begin
        dvd = NW'(gsum_q) + NW'(gcnt_q >> 1);
        dvs = gcnt_q;
      end
      SEL_GRATIO: begin
        dvd = (NW'(gdark_q) << 16) + NW'(gcnt_q >> 1);
        dvs = gcnt_q;
      end
      SEL_RMEAN: begin
        dvd = NW'(rsum_q) + NW'(rcnt_q >> 1);
        dvs = rcnt_q;
      end
      SEL_RRATIO: begin
        dvd = (NW'(rdark_q) << 16) + NW'(rcnt_q >> 1);
        dvs = rcnt_q;
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  ldps_div #(
    .NW  (NW),
    .DVW (COUNT_BITS),
    .QW  (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Accumulate, run the division sequence, hand the result to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_ACC;
      sel_q        <= SEL_GMEAN;
      gsum_q       <= '0;
      gcnt_q       <= '0;
      gdark_q      <= '0;
      rsum_q       <= '0;
      rcnt_q       <= '0;
      rdark_q      <= '0;
      gavg_q       <= '0;
      gratio_q     <= '0;
      ravg_q       <= '0;
      rratio_q     <= '0;
      svalid_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_gavg_q   <= '0;
      out_gratio_q <= '0;
      out_ravg_q   <= '0;
      out_rratio_q <= '0;
      out_svalid_q <= 1'b0;
    end else begin
      // Drop the taken word unless a new one is loaded in the same cycle
      if (out_valid_q && !out_stall_i && state_q != ST_WB) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_ACC: begin
          if (pop) begin
            if (route_i.to_global && gcnt_q != CMAX) begin
              gsum_q <= gsum_q + SW'(lum_i);
              gcnt_q <= gcnt_q + 1'b1;
              if (dark_i) begin
                gdark_q <= gdark_q + 1'b1;
              end
            end
            if (route_i.to_region && rcnt_q != CMAX) begin
              rsum_q <= rsum_q + SW'(lum_i);
              rcnt_q <= rcnt_q + 1'b1;
              if (dark_i) begin
                rdark_q <= rdark_q + 1'b1;
              end
            end
            if (route_i.last) begin
              state_q <= ST_CHK;
            end
          end
        end
        ST_CHK: begin
          // An empty set gives an all-zero, invalid result without dividing
          if (gcnt_q == '0 || rcnt_q == '0) begin
            gavg_q   <= '0;
            gratio_q <= '0;
            ravg_q   <= '0;
            rratio_q <= '0;
            svalid_q <= 1'b0;
            state_q  <= ST_WB;
          end else begin
            svalid_q <= 1'b1;
            sel_q    <= SEL_GMEAN;
            state_q  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            case (sel_q)
              SEL_GMEAN:  gavg_q   <= to_mean(div_q);
              SEL_GRATIO: gratio_q <= to_ratio(div_q);
              SEL_RMEAN:  ravg_q   <= to_mean(div_q);
              SEL_RRATIO: rratio_q <= to_ratio(div_q);
              default:    gavg_q   <= gavg_q;
            endcase
            if (sel_q == SEL_RRATIO) begin
              state_q <= ST_WB;
            end else begin
              sel_q   <= sel_q + 1'b1;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_WB: begin
          // Wait for a free output register, then clear for the next frame
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_gavg_q   <= gavg_q;
            out_gratio_q <= gratio_q;
            out_ravg_q   <= ravg_q;
            out_rratio_q <= rratio_q;
            out_svalid_q <= svalid_q;
            gsum_q       <= '0;
            gcnt_q       <= '0;
            gdark_q      <= '0;
            rsum_q       <= '0;
            rcnt_q       <= '0;
            rdark_q      <= '0;
            state_q      <= ST_ACC;
          end
        end
        default: begin
          state_q <= ST_ACC;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign global_average_o    = out_gavg_q;
  assign global_dark_ratio_o = out_gratio_q;
  assign region_average_o    = out_ravg_q;
  assign region_dark_ratio_o = out_rratio_q;
  assign stats_valid_o       = out_svalid_q;

endmodule

// ===== design/luminance_dark_pixel_stats.sv =====
// Top level of the sRGB luminance and dark-pixel statistics block.
`timescale 1ns / 1ps

// One RGBA pixel word is taken per clock while in_stall_o is low. A
// three-stage front (premultiply, linear lookup and weighting, sum and dark
// test) feeds a four-word queue; the back end adds each word to the global
// and region accumulators that its route flags select. A word marked
// last_pixel starts the end-of-frame work: four divisions on one shared
// restoring divider that produces one quotient bit per cycle, or none when
// a set is empty. During that time the back end pops nothing, so input
// stalls once the pipe and queue are full. A finished result waits in its
// own output register while new pixels keep flowing. The threshold register
// is always ready and should be written only while the block is idle.
module luminance_dark_pixel_stats import ldps_pkg::*; #(
  parameter int unsigned COUNT_BITS     = 20,
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  alpha_in_i,
  input  logic        to_global_i,
  input  logic        to_region_i,
  input  logic        last_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] global_average_o,
  output logic [16:0] global_dark_ratio_o,
  output logic [15:0] region_average_o,
  output logic [16:0] region_dark_ratio_o,
  output logic        stats_valid_o
);

  localparam int unsigned LW = LUMA_FRAC_BITS + 1;
  localparam int unsigned IW = LW + 1 + $bits(ldps_route_t);

  logic [15:0]   thr_q;
  logic          push;
  logic [LW-1:0] push_lum;
  logic          push_dark;
  ldps_route_t   push_route;
  logic          q_full, q_empty, pop;
  logic [IW-1:0] q_rd;
  logic [LW-1:0] pop_lum;
  logic          pop_dark;
  ldps_route_t   pop_route;

  // Threshold register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= DARK_THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  ldps_front #(
    .LUMA_FRAC_BITS (LUMA_FRAC_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .alpha_in_i       (alpha_in_i),
    .to_global_i      (to_global_i),
    .to_region_i      (to_region_i),
    .last_pixel_i     (last_pixel_i),
    .dark_threshold_i (thr_q),
    .queue_full_i     (q_full),
    .push_o           (push),
    .push_lum_o       (push_lum),
    .push_dark_o      (push_dark),
    .push_route_o     (push_route)
  );

  ldps_fifo #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_lum, push_dark, push_route}),
    .pop_i       (pop),
    .pop_data_o  (q_rd),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Unpack the queue word
  assign pop_lum   = q_rd[IW-1 -: LW];
  assign pop_dark  = q_rd[$bits(ldps_route_t)];
  assign pop_route = ldps_route_t'(q_rd[$bits(ldps_route_t)-1:0]);

  ldps_back #(
    .COUNT_BITS     (COUNT_BITS),
    .LUMA_FRAC_BITS (LUMA_FRAC_BITS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .queue_empty_i       (q_empty),
    .pop_o               (pop),
    .lum_i               (pop_lum),
    .dark_i              (pop_dark),
    .route_i             (pop_route),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .global_average_o    (global_average_o),
    .global_dark_ratio_o (global_dark_ratio_o),
    .region_average_o    (region_average_o),
    .region_dark_ratio_o (region_dark_ratio_o),
    .stats_valid_o       (stats_valid_o)
  );

endmodule

// ===== design/ldps_checker.sv =====
// Port-level checks for the luminance statistics block, bound to the top level.
`timescale 1ns / 1ps

module ldps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] global_average_o,
  input logic [16:0] global_dark_ratio_o,
  input logic [15:0] region_average_o,
  input logic [16:0] region_dark_ratio_o,
  input logic        stats_valid_o
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(global_average_o) &&
      $stable(global_dark_ratio_o) && $stable(region_average_o) &&
      $stable(region_dark_ratio_o) && $stable(stats_valid_o))
    else $error("stalled result word changed");

  // An invalid result carries all-zero values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stats_valid_o |-> global_average_o == 16'd0 &&
      global_dark_ratio_o == 17'd0 && region_average_o == 16'd0 &&
      region_dark_ratio_o == 17'd0)
    else $error("invalid result with nonzero values");

  // Dark ratios never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> global_dark_ratio_o <= 17'h10000 && region_dark_ratio_o <= 17'h10000)
    else $error("dark ratio above one");

  // Reset sampled at a clock edge leaves no result word valid
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result word during reset");

endmodule

bind luminance_dark_pixel_stats ldps_checker u_ldps_checker (.*);
